>>> rtl/tcba_pkg.sv
// ----------------------------------------------------------------------------
// Two-class buffer allocator package
// Shared sizes, codes and types for the allocator and its request decoder.
// ----------------------------------------------------------------------------
package tcba_pkg;

   // Pool sizes. Large handles come first, small handles follow them.
   localparam int NUM_LARGE = 8;
   localparam int NUM_SMALL = 8;
   localparam int NUM_TOTAL = NUM_LARGE + NUM_SMALL;

   // Fixed field widths.
   localparam int HANDLE_W = 4;
   localparam int SIZE_W   = 16;
   localparam int FREE_W   = 4;
   localparam int CSR_IDX_W = 2;

   // Derived widths of the free lists.
   localparam int LARGE_PTR_W = (NUM_LARGE > 1) ? $clog2(NUM_LARGE) : 1;
   localparam int SMALL_PTR_W = (NUM_SMALL > 1) ? $clog2(NUM_SMALL) : 1;
   localparam int LARGE_CNT_W = $clog2(NUM_LARGE + 1);
   localparam int SMALL_CNT_W = $clog2(NUM_SMALL + 1);

   // Width wide enough to compare a handle against the pool boundaries.
   localparam int HCMP_W = (HANDLE_W > $clog2(NUM_TOTAL + 1)) ?
                           HANDLE_W : $clog2(NUM_TOTAL + 1);

   // Reset values of the limit registers.
   localparam logic [SIZE_W-1:0] SMALL_LIMIT_RST = SIZE_W'(32);
   localparam logic [SIZE_W-1:0] LARGE_LIMIT_RST = SIZE_W'(128);

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SMALL_LIMIT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_LARGE_LIMIT = CSR_IDX_W'(1);

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_TOO_BIG = 2'd2,
      ST_BAD     = 2'd3
   } status_type;

   // Fill flags of both free lists, seen by the decoder.
   typedef struct packed {
      logic small_empty;
      logic small_full;
      logic large_empty;
      logic large_full;
   } pool_flags_type;

   // List operations and the status chosen for one request.
   typedef struct packed {
      logic       pop_small;
      logic       pop_large;
      logic       push_small;
      logic       push_large;
      status_type status;
   } list_op_type;

endpackage

>>> rtl/two_class_buffer_allocator.sv
// ----------------------------------------------------------------------------
// Two-class buffer allocator
// Hands out and takes back fixed buffer handles from a large and a small pool.
// ----------------------------------------------------------------------------
// The allocator accepts one request per clock cycle while req_stall is low and
// returns exactly one response for each request, in order. Each request is
// held in the input register, then the decode and free-list update pass loads
// the response register. An allocate request whose size is at most
// small_limit pops the head of the small free list; a size above small_limit
// but at most large_limit pops the large list; a larger size fails with status
// "too large". An empty chosen list fails with status "empty" and never falls
// back to the other pool. A free request pushes the handle onto the tail of
// its own pool's list (large handles are 0 to NUM_LARGE-1, small handles
// follow); a handle past the last pool, or a push into a full list, returns
// status "bad" and changes nothing. Double frees are not detected. Every
// response carries the free counts of both pools after the request. After
// reset both lists hold their handles in ascending order and the limits are
// 32 and 128. The limits may only be rewritten while no request is in flight.
module two_class_buffer_allocator (
   input  logic                              clock,
   input  logic                              reset,

   // Request channel.
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_cmd,
   input  logic [tcba_pkg::SIZE_W-1:0]       req_size,
   input  logic [tcba_pkg::HANDLE_W-1:0]     req_handle_in,

   // Response channel.
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [tcba_pkg::HANDLE_W-1:0]     rsp_handle_out,
   output logic [tcba_pkg::FREE_W-1:0]       rsp_small_free,
   output logic [tcba_pkg::FREE_W-1:0]       rsp_large_free,

   // Configuration write channel.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tcba_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tcba_pkg::SIZE_W-1:0]       csr_data
);

   localparam int NL  = tcba_pkg::NUM_LARGE;
   localparam int NS  = tcba_pkg::NUM_SMALL;
   localparam int LPW = tcba_pkg::LARGE_PTR_W;
   localparam int SPW = tcba_pkg::SMALL_PTR_W;
   localparam int LCW = tcba_pkg::LARGE_CNT_W;
   localparam int SCW = tcba_pkg::SMALL_CNT_W;
   localparam int HW  = tcba_pkg::HANDLE_W;

   // ------------------------------------------------------------------------
   // Configuration registers. The port never pushes back.
   // ------------------------------------------------------------------------
   logic [tcba_pkg::SIZE_W-1:0] small_limit_ff;
   logic [tcba_pkg::SIZE_W-1:0] large_limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         small_limit_ff <= tcba_pkg::SMALL_LIMIT_RST;
         large_limit_ff <= tcba_pkg::LARGE_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == tcba_pkg::CSR_SMALL_LIMIT) begin
            small_limit_ff <= csr_data;
         end
         if (csr_index == tcba_pkg::CSR_LARGE_LIMIT) begin
            large_limit_ff <= csr_data;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Handshake. The input register moves on whenever the response register
   // is empty or being drained in the same cycle.
   // ------------------------------------------------------------------------
   logic                        s1_valid_ff;
   tcba_pkg::cmd_type           s1_cmd_ff;
   logic [tcba_pkg::SIZE_W-1:0] s1_size_ff;
   logic [HW-1:0]               s1_handle_ff;
   logic                        rsp_valid_ff;
   logic                        out_free;
   logic                        s1_fire;
   logic                        req_fire;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_fire  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff    <= tcba_pkg::cmd_type'(req_cmd);
         s1_size_ff   <= req_size;
         s1_handle_ff <= req_handle_in;
      end
   end

   // ------------------------------------------------------------------------
   // Free lists: a circular buffer per pool with head pointer and count.
   // ------------------------------------------------------------------------
   logic [HW-1:0]  large_list_ff [NL];
   logic [LPW-1:0] large_head_ff;
   logic [LCW-1:0] large_cnt_ff;
   logic [HW-1:0]  small_list_ff [NS];
   logic [SPW-1:0] small_head_ff;
   logic [SCW-1:0] small_cnt_ff;

   logic [LPW-1:0] large_head_in;
   logic [LCW-1:0] large_cnt_in;
   logic [SPW-1:0] small_head_in;
   logic [SCW-1:0] small_cnt_in;

   logic [LCW:0]   large_tail_sum;
   logic [LCW:0]   large_tail_wrap;
   logic [LPW-1:0] large_tail;
   logic [SCW:0]   small_tail_sum;
   logic [SCW:0]   small_tail_wrap;
   logic [SPW-1:0] small_tail;

   tcba_pkg::pool_flags_type flags;
   tcba_pkg::list_op_type    op;
   logic                     do_pop_large;
   logic                     do_pop_small;
   logic                     do_push_large;
   logic                     do_push_small;

   assign flags.large_empty = (large_cnt_ff == '0);
   assign flags.large_full  = (large_cnt_ff == LCW'(NL));
   assign flags.small_empty = (small_cnt_ff == '0);
   assign flags.small_full  = (small_cnt_ff == SCW'(NS));

   tcba_decode u_decode (
      .cmd         (s1_cmd_ff),
      .req_size    (s1_size_ff),
      .handle_in   (s1_handle_ff),
      .small_limit (small_limit_ff),
      .large_limit (large_limit_ff),
      .flags       (flags),
      .op          (op)
   );

   assign do_pop_large  = s1_fire && op.pop_large;
   assign do_pop_small  = s1_fire && op.pop_small;
   assign do_push_large = s1_fire && op.push_large;
   assign do_push_small = s1_fire && op.push_small;

   // The tail sits count entries past the head, modulo the list depth.
   assign large_tail_sum  = (LCW+1)'(large_head_ff) + (LCW+1)'(large_cnt_ff);
   assign large_tail_wrap = (large_tail_sum >= (LCW+1)'(NL)) ?
                            large_tail_sum - (LCW+1)'(NL) : large_tail_sum;
   assign large_tail      = large_tail_wrap[LPW-1:0];
   assign small_tail_sum  = (SCW+1)'(small_head_ff) + (SCW+1)'(small_cnt_ff);
   assign small_tail_wrap = (small_tail_sum >= (SCW+1)'(NS)) ?
                            small_tail_sum - (SCW+1)'(NS) : small_tail_sum;
   assign small_tail      = small_tail_wrap[SPW-1:0];

   always_comb begin
      large_head_in = large_head_ff;
      large_cnt_in  = large_cnt_ff;
      small_head_in = small_head_ff;
      small_cnt_in  = small_cnt_ff;
      if (do_pop_large) begin
         large_head_in = (large_head_ff == LPW'(NL - 1)) ? '0 : large_head_ff + 1'b1;
         large_cnt_in  = large_cnt_ff - 1'b1;
      end
      if (do_push_large) begin
         large_cnt_in = large_cnt_ff + 1'b1;
      end
      if (do_pop_small) begin
         small_head_in = (small_head_ff == SPW'(NS - 1)) ? '0 : small_head_ff + 1'b1;
         small_cnt_in  = small_cnt_ff - 1'b1;
      end
      if (do_push_small) begin
         small_cnt_in = small_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         large_head_ff <= '0;
         large_cnt_ff  <= LCW'(NL);
         small_head_ff <= '0;
         small_cnt_ff  <= SCW'(NS);
         for (int i = 0; i < NL; i++) begin
            large_list_ff[i] <= HW'(i);
         end
         for (int i = 0; i < NS; i++) begin
            small_list_ff[i] <= HW'(NL + i);
         end
      end else begin
         large_head_ff <= large_head_in;
         large_cnt_ff  <= large_cnt_in;
         small_head_ff <= small_head_in;
         small_cnt_ff  <= small_cnt_in;
         if (do_push_large) begin
            large_list_ff[large_tail] <= s1_handle_ff;
         end
         if (do_push_small) begin
            small_list_ff[small_tail] <= s1_handle_ff;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response register. The handle reads as zero unless an allocate succeeds.
   // ------------------------------------------------------------------------
   tcba_pkg::status_type rsp_status_ff;
   logic [HW-1:0]        rsp_handle_ff;
   logic [HW-1:0]        rsp_handle_in;
   logic [tcba_pkg::FREE_W-1:0] rsp_small_ff;
   logic [tcba_pkg::FREE_W-1:0] rsp_large_ff;

   always_comb begin
      priority if (op.pop_small) begin
         rsp_handle_in = small_list_ff[small_head_ff];
      end else if (op.pop_large) begin
         rsp_handle_in = large_list_ff[large_head_ff];
      end else begin
         rsp_handle_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_status_ff <= op.status;
         rsp_handle_ff <= rsp_handle_in;
         rsp_small_ff  <= tcba_pkg::FREE_W'(small_cnt_in);
         rsp_large_ff  <= tcba_pkg::FREE_W'(large_cnt_in);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_small_free = rsp_small_ff;
   assign rsp_large_free = rsp_large_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   a_large_cnt_range: assert property (@(posedge clock) disable iff (reset)
      large_cnt_ff <= LCW'(NL))
      else $error("large free count exceeds pool size");

   a_small_cnt_range: assert property (@(posedge clock) disable iff (reset)
      small_cnt_ff <= SCW'(NS))
      else $error("small free count exceeds pool size");

   a_small_pop_count: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && op.pop_small) |=> (small_cnt_ff == $past(small_cnt_ff) - 1'b1))
      else $error("small pop did not lower the free count by one");

   a_handle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != tcba_pkg::ST_OK) |-> (rsp_handle_ff == '0))
      else $error("failed request returned a nonzero handle");

endmodule

>>> rtl/tcba_decode.sv
// ----------------------------------------------------------------------------
// Two-class buffer allocator request decoder
// Picks the pool and the list operation for one request and sets its status.
// ----------------------------------------------------------------------------
module tcba_decode (
   input  tcba_pkg::cmd_type                cmd,
   input  logic [tcba_pkg::SIZE_W-1:0]      req_size,
   input  logic [tcba_pkg::HANDLE_W-1:0]    handle_in,
   input  logic [tcba_pkg::SIZE_W-1:0]      small_limit,
   input  logic [tcba_pkg::SIZE_W-1:0]      large_limit,
   input  tcba_pkg::pool_flags_type         flags,
   output tcba_pkg::list_op_type            op
);

   logic [tcba_pkg::HCMP_W-1:0] handle_x;

   assign handle_x = tcba_pkg::HCMP_W'(handle_in);

   always_comb begin
      op            = '0;
      op.status     = tcba_pkg::ST_OK;
      unique case (cmd)
         tcba_pkg::CMD_ALLOC: begin
            // The large limit is tested first, so a size within both limits
            // always goes to the small pool.
            priority if (req_size > large_limit) begin
               op.status = tcba_pkg::ST_TOO_BIG;
            end else if (req_size <= small_limit) begin
               if (flags.small_empty) begin
                  op.status = tcba_pkg::ST_EMPTY;
               end else begin
                  op.pop_small = 1'b1;
               end
            end else begin
               if (flags.large_empty) begin
                  op.status = tcba_pkg::ST_EMPTY;
               end else begin
                  op.pop_large = 1'b1;
               end
            end
         end
         tcba_pkg::CMD_FREE: begin
            priority if (handle_x >= tcba_pkg::HCMP_W'(tcba_pkg::NUM_TOTAL)) begin
               op.status = tcba_pkg::ST_BAD;
            end else if (handle_x >= tcba_pkg::HCMP_W'(tcba_pkg::NUM_LARGE)) begin
               if (flags.small_full) begin
                  op.status = tcba_pkg::ST_BAD;
               end else begin
                  op.push_small = 1'b1;
               end
            end else begin
               if (flags.large_full) begin
                  op.status = tcba_pkg::ST_BAD;
               end else begin
                  op.push_large = 1'b1;
               end
            end
         end
         default: begin
            op.status = tcba_pkg::ST_BAD;
         end
      endcase
   end

endmodule
